// ----- sv/symmetric_dash_segment_generator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the symmetric dash segment generator.
// Each macro expects clk and rst_n to be visible in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_DASH_SEGMENT_GENERATOR_ASSERT_SVH
`define SYMMETRIC_DASH_SEGMENT_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDSG_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdsg assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SDSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdsg assertion failed");

`endif

// ----- sv/sdsg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sdsg_pkg
// Shared widths, codes, control structs and coordinate helper for the
// symmetric dash segment generator.
// ============================================================================
package sdsg_pkg;

    localparam int COORD_W    = 32;
    localparam int CFG_W      = 24;
    localparam int DMAG_W     = 33;
    localparam int LEN_W      = 34;
    localparam int LEFT_W     = 33;
    localparam int T_W        = 34;
    localparam int UMAG_W     = 31;
    localparam int SUM_W      = 68;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = T_W + MUL_B_W;
    localparam int OFF_W      = 35;
    localparam int REM_W      = 38;
    localparam int DREM_W     = 35;
    localparam int SQRT_STEPS = 34;
    localparam int DIV_STEPS  = 31;
    localparam int CNT_W      = 6;

    localparam logic [CFG_W-1:0] DASH_LENGTH_RESET = 24'd9830;
    localparam logic [CFG_W-1:0] DASH_GAP_RESET    = 24'd29491;
    localparam logic [CFG_W:0]   HALF_UNIT         = 25'd32768;

    typedef enum logic [0:0] {
        REG_DASH_LENGTH = 1'b0,
        REG_DASH_GAP    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUT_MODE_FWD   = 2'd0,
        OUT_MODE_REV   = 2'd1,
        OUT_MODE_WHOLE = 2'd2
    } out_mode_t;

    typedef enum logic [17:0] {
        S_IDLE    = 18'b000000000000000001,
        S_SQ_LO   = 18'b000000000000000010,
        S_SQ_HI   = 18'b000000000000000100,
        S_SQ_ACC  = 18'b000000000000001000,
        S_SUM     = 18'b000000000000010000,
        S_SQRT    = 18'b000000000000100000,
        S_CHECK   = 18'b000000000001000000,
        S_WHOLE   = 18'b000000000010000000,
        S_DIV     = 18'b000000000100000000,
        S_COUNT   = 18'b000000001000000000,
        S_START   = 18'b000000010000000000,
        S_TSET    = 18'b000000100000000000,
        S_TLO     = 18'b000001000000000000,
        S_THI     = 18'b000010000000000000,
        S_TACC    = 18'b000100000000000000,
        S_TSAVE   = 18'b001000000000000000,
        S_OUT_FWD = 18'b010000000000000000,
        S_OUT_REV = 18'b100000000000000000
    } state_t;

    typedef struct packed {
        logic      load_in;
        logic      mul_lo;
        logic      mul_hi;
        logic      mul_acc;
        logic      mul_dash;
        logic      sum_en;
        logic      sqrt_step;
        logic      div_init;
        logic      div_step;
        logic      count_init;
        logic      sub_period;
        logic      sub_gap;
        logic      walk_init;
        logic      walk_advance;
        logic      t_load;
        logic      t_second;
        logic      t_tail;
        logic      save_off0;
        logic      save_off1;
        logic      out_load;
        out_mode_t out_mode;
        logic      out_last;
        logic      out_capped;
    } cmd_t;

    typedef struct packed {
        logic len_tiny;
        logic gap_small;
        logic length_big;
        logic left_gt_period;
        logic left_gt_gap;
        logic out_free;
    } sts_t;

    function automatic logic [COORD_W-1:0] place_coord(
        input logic signed [COORD_W-1:0] mid,
        input logic [OFF_W-1:0]          off,
        input logic                      neg
    );
        logic signed [OFF_W+1:0] moff;
        logic signed [OFF_W+1:0] wide;
        moff = signed'({2'b00, off});
        wide = signed'({{(OFF_W+2-COORD_W){mid[COORD_W-1]}}, mid}) + (neg ? -moff : moff);
        if (wide > 37'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        else if (wide < -37'sd2147483648)
        begin
            return 32'h80000000;
        end
        else
        begin
            return wide[COORD_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/sdsg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "symmetric_dash_segment_generator_assert.svh"
// ============================================================================
// sdsg_ctrl
// Controller: sequences the squares, root, divides, dash count pre-pass and
// the per-pair placement and output beats.
// ============================================================================
module sdsg_ctrl
    import sdsg_pkg::*;
#(
    parameter int MAX_DASHES = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam int PAIRS = MAX_DASHES / 2;
    localparam int NPW   = $clog2(PAIRS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NPW-1:0]   npairs_reg, npairs_next;
    logic [NPW-1:0]   pidx_reg, pidx_next;
    logic             tail_reg, tail_next;
    logic             capped_reg, capped_next;
    logic             tphase_reg, tphase_next;
    logic             is_tail;
    logic             final_pair;

    assign in_stall   = (state_reg != S_IDLE);
    assign is_tail    = tail_reg && (pidx_reg == npairs_reg);
    assign final_pair = tail_reg ? is_tail : (pidx_reg == (npairs_reg - NPW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            npairs_reg <= '0;
            pidx_reg   <= '0;
            tail_reg   <= 1'b0;
            capped_reg <= 1'b0;
            tphase_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            npairs_reg <= npairs_next;
            pidx_reg   <= pidx_next;
            tail_reg   <= tail_next;
            capped_reg <= capped_next;
            tphase_reg <= tphase_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        npairs_next = npairs_reg;
        pidx_next   = pidx_reg;
        tail_next   = tail_reg;
        capped_next = capped_reg;
        tphase_next = tphase_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SQ_LO;
                end
            end
            S_SQ_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_SQ_HI;
            end
            S_SQ_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.len_tiny)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.gap_small)
                begin
                    state_next = sts.length_big ? S_WHOLE : S_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_WHOLE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_mode = OUT_MODE_WHOLE;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cmd.count_init = 1'b1;
                    npairs_next    = '0;
                    tail_next      = 1'b0;
                    capped_next    = 1'b0;
                    state_next     = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (sts.left_gt_period)
                begin
                    if (npairs_reg == NPW'(PAIRS))
                    begin
                        capped_next = 1'b1;
                        state_next  = S_START;
                    end
                    else
                    begin
                        cmd.sub_period = 1'b1;
                        npairs_next    = npairs_reg + NPW'(1);
                    end
                end
                else
                begin
                    if (sts.left_gt_gap)
                    begin
                        if (npairs_reg == NPW'(PAIRS))
                        begin
                            capped_next = 1'b1;
                        end
                        else
                        begin
                            cmd.sub_gap = 1'b1;
                            tail_next   = 1'b1;
                        end
                    end
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if ((npairs_reg == '0) && !tail_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    pidx_next     = '0;
                    tphase_next   = 1'b0;
                    state_next    = S_TSET;
                end
            end
            S_TSET:
            begin
                cmd.t_load   = 1'b1;
                cmd.t_second = tphase_reg;
                cmd.t_tail   = is_tail;
                state_next   = S_TLO;
            end
            S_TLO:
            begin
                cmd.mul_lo   = 1'b1;
                cmd.mul_dash = 1'b1;
                state_next   = S_THI;
            end
            S_THI:
            begin
                cmd.mul_hi   = 1'b1;
                cmd.mul_dash = 1'b1;
                state_next   = S_TACC;
            end
            S_TACC:
            begin
                cmd.mul_acc = 1'b1;
                state_next  = S_TSAVE;
            end
            S_TSAVE:
            begin
                cmd.save_off0 = !tphase_reg;
                cmd.save_off1 = tphase_reg;
                if (tphase_reg)
                begin
                    state_next = S_OUT_FWD;
                end
                else
                begin
                    tphase_next = 1'b1;
                    state_next  = S_TSET;
                end
            end
            S_OUT_FWD:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_mode   = OUT_MODE_FWD;
                    cmd.out_capped = capped_reg;
                    state_next     = S_OUT_REV;
                end
            end
            S_OUT_REV:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_mode   = OUT_MODE_REV;
                    cmd.out_capped = capped_reg;
                    cmd.out_last   = final_pair;
                    if (final_pair)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.walk_advance = 1'b1;
                        pidx_next        = pidx_reg + NPW'(1);
                        tphase_next      = 1'b0;
                        state_next       = S_TSET;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `SDSG_ASSERT_IMPLIES(a_load_only_when_free, cmd.out_load, sts.out_free)
    `SDSG_ASSERT_IMPLIES(a_sqrt_count_bound, state_reg == S_SQRT, cnt_reg < CNT_W'(SQRT_STEPS))
    `SDSG_ASSERT_IMPLIES(a_pairs_bound, state_reg == S_OUT_REV, pidx_reg <= npairs_reg)
    `SDSG_ASSERT_NEXT(a_accept_starts_work, cmd.load_in, state_reg == S_SQ_LO)

endmodule
`default_nettype wire

// ----- sv/sdsg_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "symmetric_dash_segment_generator_assert.svh"
// ============================================================================
// sdsg_datapath
// Datapath: configuration registers, three multiplier lanes, bit-serial
// square root, three restoring dividers, dash walk and output register.
// ============================================================================
module sdsg_datapath
    import sdsg_pkg::*;
#(
    parameter int TINY_LENGTH = 7
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic signed [COORD_W-1:0] first_x,
    input  wire logic signed [COORD_W-1:0] first_y,
    input  wire logic signed [COORD_W-1:0] first_z,
    input  wire logic signed [COORD_W-1:0] second_x,
    input  wire logic signed [COORD_W-1:0] second_y,
    input  wire logic signed [COORD_W-1:0] second_z,
    input  wire cmd_t                      cmd,
    output sts_t                           sts,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [COORD_W-1:0]      dash_start_x,
    output logic signed [COORD_W-1:0]      dash_start_y,
    output logic signed [COORD_W-1:0]      dash_start_z,
    output logic signed [COORD_W-1:0]      dash_end_x,
    output logic signed [COORD_W-1:0]      dash_end_y,
    output logic signed [COORD_W-1:0]      dash_end_z,
    output logic                           last_dash,
    output logic                           capped
);

    localparam logic [LEN_W-1:0] TINY = LEN_W'(TINY_LENGTH);

    logic [CFG_W-1:0]          dash_length_reg;
    logic [CFG_W-1:0]          gap_len_reg;
    logic                      out_valid_reg;

    logic signed [COORD_W-1:0] a_reg   [3];
    logic signed [COORD_W-1:0] b_reg   [3];
    logic signed [COORD_W-1:0] mid_reg [3];
    logic [DMAG_W-1:0]         dmag_reg[3];
    logic                      dneg_reg[3];
    logic [PROD_W-1:0]         prod_reg[3];
    logic [SUM_W-1:0]          acc_reg [3];
    logic [DREM_W-1:0]         drem_reg[3];
    logic [UMAG_W-1:0]         q_reg   [3];
    logic [OFF_W-1:0]          off0_reg[3];
    logic [OFF_W-1:0]          off1_reg[3];
    logic [SUM_W-1:0]          rad_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [LEN_W-1:0]          root_reg;
    logic [LEFT_W-1:0]         left_reg;
    logic [T_W-1:0]            used_reg;
    logic [T_W-1:0]            t_reg;

    logic signed [COORD_W-1:0] in_a[3];
    logic signed [COORD_W-1:0] in_b[3];
    logic [CFG_W:0]            period_raw;
    logic [CFG_W:0]            period;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-1:0]          trial;
    logic                      root_ge;
    logic                      out_free;

    assign in_a[0] = first_x;
    assign in_a[1] = first_y;
    assign in_a[2] = first_z;
    assign in_b[0] = second_x;
    assign in_b[1] = second_y;
    assign in_b[2] = second_z;

    assign period_raw = {1'b0, dash_length_reg} + {1'b0, gap_len_reg};
    assign period     = (LEN_W'(period_raw) < TINY) ? HALF_UNIT : period_raw;

    assign rem_sh  = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
    assign trial   = REM_W'({root_reg, 2'b01});
    assign root_ge = (rem_sh >= trial);

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    assign sts.len_tiny       = (root_reg <= TINY);
    assign sts.gap_small      = (LEN_W'(gap_len_reg) <= TINY);
    assign sts.length_big     = (LEN_W'(dash_length_reg) > TINY);
    assign sts.left_gt_period = (left_reg > LEFT_W'(period));
    assign sts.left_gt_gap    = (left_reg > LEFT_W'(gap_len_reg));
    assign sts.out_free       = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_length_reg <= DASH_LENGTH_RESET;
            gap_len_reg     <= DASH_GAP_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DASH_LENGTH: dash_length_reg <= cfg_data;
                    REG_DASH_GAP:    gap_len_reg     <= cfg_data;
                    default:         gap_len_reg     <= gap_len_reg;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [COORD_W:0] d;
            logic signed [COORD_W:0] s;
            logic [T_W-1:0]          a_op;
            logic [MUL_B_W-1:0]      b_op;
            logic [DREM_W-1:0]       dd;
            logic                    dge;
            d = {in_b[i][COORD_W-1], in_b[i]} - {in_a[i][COORD_W-1], in_a[i]};
            s = {in_b[i][COORD_W-1], in_b[i]} + {in_a[i][COORD_W-1], in_a[i]};
            if (cmd.mul_dash)
            begin
                a_op = t_reg;
                b_op = cmd.mul_hi ? MUL_B_W'(q_reg[i][UMAG_W-1:MUL_B_W])
                                  : q_reg[i][MUL_B_W-1:0];
            end
            else
            begin
                a_op = T_W'(dmag_reg[i]);
                b_op = cmd.mul_hi ? MUL_B_W'(dmag_reg[i][DMAG_W-1:MUL_B_W])
                                  : dmag_reg[i][MUL_B_W-1:0];
            end
            dge = (drem_reg[i] >= DREM_W'(root_reg));
            dd  = dge ? (drem_reg[i] - DREM_W'(root_reg)) : drem_reg[i];

            if (cmd.load_in)
            begin
                a_reg[i]    <= in_a[i];
                b_reg[i]    <= in_b[i];
                dneg_reg[i] <= d[COORD_W];
                dmag_reg[i] <= d[COORD_W] ? DMAG_W'(-d) : DMAG_W'(d);
                mid_reg[i]  <= s[COORD_W:1];
            end
            if (cmd.mul_lo || cmd.mul_hi)
            begin
                prod_reg[i] <= PROD_W'(a_op) * PROD_W'(b_op);
            end
            if (cmd.mul_hi)
            begin
                acc_reg[i] <= SUM_W'(prod_reg[i]);
            end
            else if (cmd.mul_acc)
            begin
                acc_reg[i] <= acc_reg[i] + SUM_W'({prod_reg[i], {MUL_B_W{1'b0}}});
            end
            if (cmd.div_init)
            begin
                drem_reg[i] <= DREM_W'(dmag_reg[i]);
                q_reg[i]    <= '0;
            end
            else if (cmd.div_step)
            begin
                drem_reg[i] <= {dd[DREM_W-2:0], 1'b0};
                q_reg[i]    <= {q_reg[i][UMAG_W-2:0], dge};
            end
            if (cmd.save_off0)
            begin
                off0_reg[i] <= acc_reg[i][OFF_W+29:30];
            end
            if (cmd.save_off1)
            begin
                off1_reg[i] <= acc_reg[i][OFF_W+29:30];
            end
        end

        if (cmd.sum_en)
        begin
            rad_reg  <= acc_reg[0] + acc_reg[1] + acc_reg[2];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[LEN_W-2:0], root_ge};
        end

        if (cmd.count_init)
        begin
            left_reg <= root_reg[LEN_W-1:1];
        end
        else if (cmd.sub_period)
        begin
            left_reg <= left_reg - LEFT_W'(period);
        end
        else if (cmd.sub_gap)
        begin
            left_reg <= left_reg - LEFT_W'(gap_len_reg);
        end

        if (cmd.walk_init)
        begin
            used_reg <= '0;
        end
        else if (cmd.walk_advance)
        begin
            used_reg <= used_reg + T_W'(period);
        end

        if (cmd.t_load)
        begin
            if (cmd.t_second)
            begin
                t_reg <= used_reg + T_W'(gap_len_reg[CFG_W-1:1])
                       + (cmd.t_tail ? T_W'(left_reg) : T_W'(dash_length_reg));
            end
            else
            begin
                t_reg <= used_reg + T_W'(gap_len_reg[CFG_W-1:1]);
            end
        end

        if (cmd.out_load)
        begin
            last_dash <= cmd.out_last;
            capped    <= cmd.out_capped;
            case (cmd.out_mode)
                OUT_MODE_WHOLE:
                begin
                    dash_start_x <= a_reg[0];
                    dash_start_y <= a_reg[1];
                    dash_start_z <= a_reg[2];
                    dash_end_x   <= b_reg[0];
                    dash_end_y   <= b_reg[1];
                    dash_end_z   <= b_reg[2];
                end
                OUT_MODE_REV:
                begin
                    dash_start_x <= place_coord(mid_reg[0], off0_reg[0], !dneg_reg[0]);
                    dash_start_y <= place_coord(mid_reg[1], off0_reg[1], !dneg_reg[1]);
                    dash_start_z <= place_coord(mid_reg[2], off0_reg[2], !dneg_reg[2]);
                    dash_end_x   <= place_coord(mid_reg[0], off1_reg[0], !dneg_reg[0]);
                    dash_end_y   <= place_coord(mid_reg[1], off1_reg[1], !dneg_reg[1]);
                    dash_end_z   <= place_coord(mid_reg[2], off1_reg[2], !dneg_reg[2]);
                end
                default:
                begin
                    dash_start_x <= place_coord(mid_reg[0], off0_reg[0], dneg_reg[0]);
                    dash_start_y <= place_coord(mid_reg[1], off0_reg[1], dneg_reg[1]);
                    dash_start_z <= place_coord(mid_reg[2], off0_reg[2], dneg_reg[2]);
                    dash_end_x   <= place_coord(mid_reg[0], off1_reg[0], dneg_reg[0]);
                    dash_end_y   <= place_coord(mid_reg[1], off1_reg[1], dneg_reg[1]);
                    dash_end_z   <= place_coord(mid_reg[2], off1_reg[2], dneg_reg[2]);
                end
            endcase
        end
    end

    // The root remainder never exceeds twice the partial root.
    `SDSG_ASSERT_NEXT(a_root_rem_bound, cmd.sqrt_step, rem_reg <= REM_W'({root_reg, 1'b0}))
    `SDSG_ASSERT_NEXT(a_load_shows_beat, cmd.out_load, out_valid_reg)

endmodule
`default_nettype wire

// ----- sv/symmetric_dash_segment_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// symmetric_dash_segment_generator
// Turns one 3D segment into dashes placed symmetrically about its midpoint.
// ============================================================================
// Usage:
// An input beat (in_valid high, in_stall low) carries the two endpoints of a
// segment in Q16.16. Each result beat (out_valid high, out_stall low) carries
// one dash; last_dash marks the final dash of a segment, and capped is set on
// every dash of a segment whose emission stopped at MAX_DASHES.
// The block works on one segment at a time and holds in_stall high until the
// last dash has been loaded into the output register.
// Steps: squaring, sum, bit-serial square root, a length check that may end
// the segment or emit it whole, restoring divide, dash counting and, for each
// mirrored dash pair, placement on the three shared multiplier lanes.
// The dash length and gap registers are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. Reset restores their default values and
// empties the output register. When the receiver stalls, the pending dash
// holds and the walk waits for the output register to free.
// ============================================================================
module symmetric_dash_segment_generator
    import sdsg_pkg::*;
#(
    parameter int MAX_DASHES  = 64,
    parameter int TINY_LENGTH = 7
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [COORD_W-1:0] first_x,
    input  wire logic signed [COORD_W-1:0] first_y,
    input  wire logic signed [COORD_W-1:0] first_z,
    input  wire logic signed [COORD_W-1:0] second_x,
    input  wire logic signed [COORD_W-1:0] second_y,
    input  wire logic signed [COORD_W-1:0] second_z,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [COORD_W-1:0]      dash_start_x,
    output logic signed [COORD_W-1:0]      dash_start_y,
    output logic signed [COORD_W-1:0]      dash_start_z,
    output logic signed [COORD_W-1:0]      dash_end_x,
    output logic signed [COORD_W-1:0]      dash_end_y,
    output logic signed [COORD_W-1:0]      dash_end_z,
    output logic                           last_dash,
    output logic                           capped
);

    cmd_t cmd;
    sts_t sts;

    sdsg_ctrl #(
        .MAX_DASHES (MAX_DASHES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sdsg_datapath #(
        .TINY_LENGTH (TINY_LENGTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .first_x      (first_x),
        .first_y      (first_y),
        .first_z      (first_z),
        .second_x     (second_x),
        .second_y     (second_y),
        .second_z     (second_z),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .dash_start_x (dash_start_x),
        .dash_start_y (dash_start_y),
        .dash_start_z (dash_start_z),
        .dash_end_x   (dash_end_x),
        .dash_end_y   (dash_end_y),
        .dash_end_z   (dash_end_z),
        .last_dash    (last_dash),
        .capped       (capped)
    );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the symmetric dash segment generator. A directed
// table covers tiny segments, coordinate extremes, the whole-segment case and
// the capped walk. Random segments then run under several dash settings and
// idling patterns. Every output beat is compared with an in-bench predictor.
// ============================================================================
module tb_top;
    import sdsg_pkg::*;

    typedef struct packed {
        logic signed [31:0] ax, ay, az, bx, by, bz;
    } segment_t;

    typedef struct packed {
        logic [31:0] sx, sy, sz, ex, ey, ez;
        logic        last;
        logic        capped;
    } dash_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_WHOLE} row_kind_t;

    typedef struct packed {
        logic [23:0] dl;
        logic [23:0] dg;
        segment_t    seg;
        row_kind_t   kind;
    } row_t;

    localparam int MAX_DASHES  = 64;
    localparam int TINY_LENGTH = 7;
    localparam logic signed [31:0] CMAX = 32'sh7fffffff;
    localparam logic signed [31:0] CMIN = 32'sh80000000;
    localparam logic [23:0] FULL24 = 24'hffffff;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    cfg_reg_t cfg_index = REG_DASH_LENGTH;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] dash_start_x, dash_start_y, dash_start_z;
    logic signed [31:0] dash_end_x, dash_end_y, dash_end_z;
    logic last_dash, capped;

    dash_t pending_dashes[$];
    logic [23:0] cur_length = DASH_LENGTH_RESET;
    logic [23:0] cur_gap = DASH_GAP_RESET;
    int errors = 0;
    int send_pct = 0;
    int recv_pct = 0;
    bit hold_req = 0;
    int hold_cnt = 0;

    symmetric_dash_segment_generator u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .dash_start_x(dash_start_x), .dash_start_y(dash_start_y),
        .dash_start_z(dash_start_z), .dash_end_x(dash_end_x),
        .dash_end_y(dash_end_y), .dash_end_z(dash_end_z),
        .last_dash(last_dash), .capped(capped)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [31:0] place_point(logic signed [32:0] mid,
                                                longint unsigned umag, bit uneg,
                                                longint unsigned t, bit neg_dir);
        longint unsigned off;
        logic signed [66:0] wide;
        off = (umag * t) >> 30;
        wide = mid;
        if (uneg != neg_dir)
            wide = wide - signed'({3'b000, off});
        else
            wide = wide + signed'({3'b000, off});
        if (wide > 67'sd2147483647)
            return 32'h7fffffff;
        if (wide < -67'sd2147483648)
            return 32'h80000000;
        return wide[31:0];
    endfunction

    task automatic predict_dashes(segment_t s);
        logic signed [32:0] a[3], b[3], mid[3], d;
        logic [32:0] dmag[3];
        bit dneg[3];
        longint unsigned umag[3];
        logic [67:0] sumsq, sq;
        logic [33:0] len, cand;
        longint unsigned period, left, used, hg, t0, t1;
        dash_t found[$];
        dash_t dd;
        bit cap;
        cap = 0;
        a[0] = s.ax; a[1] = s.ay; a[2] = s.az;
        b[0] = s.bx; b[1] = s.by; b[2] = s.bz;
        sumsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            d = b[i] - a[i];
            dneg[i] = d < 0;
            dmag[i] = dneg[i] ? -d : d;
            sumsq = sumsq + {35'b0, dmag[i]} * {35'b0, dmag[i]};
            mid[i] = (a[i] + b[i]) >>> 1;
        end
        len = '0;
        for (int k = 33; k >= 0; k--)
        begin
            cand = len | (34'd1 << k);
            sq = {34'b0, cand} * {34'b0, cand};
            if (sq <= sumsq)
                len = cand;
        end
        if (len <= TINY_LENGTH)
            return;
        period = cur_length + cur_gap;
        if (period < TINY_LENGTH)
            period = HALF_UNIT;
        if (cur_gap > TINY_LENGTH)
        begin
            left = len >> 1;
            used = 0;
            hg = cur_gap >> 1;
            for (int i = 0; i < 3; i++)
                umag[i] = {31'b0, dmag[i]} * 64'd1073741824 / len;
            forever
            begin
                if (left > period)
                begin
                    if (found.size() + 2 > MAX_DASHES)
                    begin
                        cap = 1;
                        break;
                    end
                    t0 = used + hg;
                    t1 = used + cur_length + hg;
                    left = left - period;
                    used = used + period;
                end
                else if (left > cur_gap)
                begin
                    if (found.size() + 2 > MAX_DASHES)
                    begin
                        cap = 1;
                        break;
                    end
                    left = left - cur_gap;
                    t0 = used + hg;
                    t1 = used + left + hg;
                    left = 0;
                end
                else
                    break;
                for (int sd = 0; sd < 2; sd++)
                begin
                    dd.sx = place_point(mid[0], umag[0], dneg[0], t0, sd == 1);
                    dd.sy = place_point(mid[1], umag[1], dneg[1], t0, sd == 1);
                    dd.sz = place_point(mid[2], umag[2], dneg[2], t0, sd == 1);
                    dd.ex = place_point(mid[0], umag[0], dneg[0], t1, sd == 1);
                    dd.ey = place_point(mid[1], umag[1], dneg[1], t1, sd == 1);
                    dd.ez = place_point(mid[2], umag[2], dneg[2], t1, sd == 1);
                    dd.last = 0;
                    dd.capped = 0;
                    found.push_back(dd);
                end
            end
        end
        else if (cur_length > TINY_LENGTH)
        begin
            dd = '{s.ax, s.ay, s.az, s.bx, s.by, s.bz, 1'b0, 1'b0};
            found.push_back(dd);
        end
        for (int i = 0; i < found.size(); i++)
        begin
            found[i].capped = cap;
            found[i].last = (i == found.size() - 1);
            pending_dashes.push_back(found[i]);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req && hold_cnt == 0)
        begin
            hold_cnt = 3000;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_pct);
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        dash_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dashes.size() == 0)
            begin
                $error("dash beat with no dash expected");
                errors++;
            end
            else
            begin
                e = pending_dashes.pop_front();
                check_field("dash_start_x", e.sx, dash_start_x);
                check_field("dash_start_y", e.sy, dash_start_y);
                check_field("dash_start_z", e.sz, dash_start_z);
                check_field("dash_end_x", e.ex, dash_end_x);
                check_field("dash_end_y", e.ey, dash_end_y);
                check_field("dash_end_z", e.ez, dash_end_z);
                check_field("last_dash", e.last, last_dash);
                check_field("capped", e.capped, capped);
            end
        end
    end

    task automatic drive_segment(segment_t s, row_kind_t kind);
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        first_x <= s.ax; first_y <= s.ay; first_z <= s.az;
        second_x <= s.bx; second_y <= s.by; second_z <= s.bz;
        do @(posedge clk); while (in_stall);
        if (kind == ROW_PREDICT)
            predict_dashes(s);
        else if (kind == ROW_WHOLE)
            pending_dashes.push_back(dash_t'{s.ax, s.ay, s.az, s.bx, s.by, s.bz,
                                             1'b1, 1'b0});
        @(negedge clk);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_dashes.size() > 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic set_dash_config(logic [23:0] dl, logic [23:0] dg);
        cfg_we <= 1'b1;
        cfg_index <= REG_DASH_LENGTH;
        cfg_data <= dl;
        @(negedge clk);
        cfg_index <= REG_DASH_GAP;
        cfg_data <= dg;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_length = dl;
        cur_gap = dg;
        @(negedge clk);
    endtask

    function automatic segment_t random_segment();
        segment_t s;
        int sel;
        logic signed [31:0] span;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 62)
            span = 32'sd1 << $urandom_range(20, 8);
        else if (sel < 72)
            span = 32'sd9;
        else
            return s;
        s.bx = s.ax + $signed($urandom_range(2 * span)) - span;
        s.by = s.ay + $signed($urandom_range(2 * span)) - span;
        s.bz = s.az + $signed($urandom_range(2 * span)) - span;
        if (sel < 20)
        begin
            s.by = s.ay;
            s.bz = s.az;
        end
        return s;
    endfunction

    row_t directed_rows[] = '{
        '{DASH_LENGTH_RESET, DASH_GAP_RESET, '{0, 0, 0, 0, 0, 0}, ROW_NONE},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET, '{0, 0, 0, 7, 0, 0}, ROW_NONE},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET, '{0, 0, 0, 0, 8, 0}, ROW_PREDICT},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET,
          '{0, 0, 0, 32'sd655360, 0, 0}, ROW_PREDICT},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET,
          '{32'sd65536, -32'sd131072, 32'sd5, -32'sd300000, 32'sd400000, -32'sd7},
          ROW_PREDICT},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET,
          '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, ROW_PREDICT},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET,
          '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, ROW_PREDICT},
        '{DASH_LENGTH_RESET, DASH_GAP_RESET,
          '{CMAX, 0, CMIN, CMAX, 0, CMAX}, ROW_PREDICT},
        '{FULL24, 24'd0, '{1, 2, 3, 32'sd262144, -32'sd327680, 6}, ROW_WHOLE},
        '{FULL24, 24'd0, '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}, ROW_WHOLE},
        '{FULL24, 24'd0, '{5, 5, 5, 5, 5, 5}, ROW_NONE},
        '{24'd0, 24'd7, '{0, 0, 0, 32'sd655360, 0, 0}, ROW_NONE},
        '{24'd0, 24'd0, '{0, 0, 0, 32'sd655360, 0, 0}, ROW_NONE},
        '{24'd8, 24'd7, '{0, 0, 0, 32'sd655360, 0, 0}, ROW_WHOLE},
        '{24'd0, 24'd8, '{0, 0, 0, 32'sd655360, 32'sd700, 0}, ROW_PREDICT},
        '{24'd0, 24'd8, '{CMIN, 0, 0, CMAX, 0, 0}, ROW_PREDICT},
        '{FULL24, FULL24, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, ROW_PREDICT},
        '{FULL24, FULL24, '{0, 0, 0, 0, -32'sd3000000, 0}, ROW_PREDICT}
    };

    logic [23:0] batch_length[6] = '{DASH_LENGTH_RESET, 24'd0, FULL24, 24'd65536,
                                     24'd20000, 24'd3000};
    logic [23:0] batch_gap[6] = '{DASH_GAP_RESET, 24'd8, FULL24, 24'd65536,
                                  24'd5, 24'd9000};

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].dl != cur_length || directed_rows[i].dg != cur_gap)
            begin
                drain_block();
                set_dash_config(directed_rows[i].dl, directed_rows[i].dg);
            end
            drive_segment(directed_rows[i].seg, directed_rows[i].kind);
        end
        for (int batch = 0; batch < 6; batch++)
        begin
            drain_block();
            if (batch == 5)
                set_dash_config(24'($urandom_range(FULL24 >> 6)),
                                24'($urandom_range(FULL24 >> 6)));
            else
                set_dash_config(batch_length[batch], batch_gap[batch]);
            send_pct = (batch < 2) ? 15 : (batch < 4) ? 83 : 0;
            recv_pct = (batch < 2) ? 83 : (batch < 4) ? 15 : 0;
            if (batch == 4)
                hold_req = 1;
            for (int n = 0; n < 72; n++)
                drive_segment(random_segment(), ROW_PREDICT);
        end
        in_valid <= 1'b0;
        while (pending_dashes.size() > 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/sdsg_pkg.sv
sv/sdsg_ctrl.sv
sv/sdsg_datapath.sv
sv/symmetric_dash_segment_generator.sv
bench/tb_top.sv
